// ===== sv/chm_pkg.sv =====
// chm_pkg: shared types, codes and constants of the chained hash map engine
// no dependencies; used by chm_hash and chained_hash_map_engine
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

  // default sizes
  localparam int DEF_BUCKETS = 1024;
  localparam int DEF_NODES   = 1024;

  // field widths
  localparam int CFG_W  = 11;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;

  // fmix64 finalizer constants
  localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          FMIX_SHIFT = 33;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZERO_VAL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_DIV
  } hash_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_HEADW,
    S_NODE,
    S_NODEW,
    S_ACT
  } eng_state_t;

  // request from the sequencer to the hash unit
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [CFG_W-1:0] divisor;
  } hash_req_t;

  // answer of the hash unit
  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] bucket;
  } hash_rsp_t;

endpackage

`default_nettype wire

// ===== sv/chained_hash_map_engine.sv =====
// chained_hash_map_engine: key-to-value map with chained buckets and a node pool
// depends on chm_pkg and chm_hash (which holds chm_mul32)
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid / in_tready | tuser: mode; tdata: key, value
//  out_    | out | out_tvalid/out_tready | tuser: status; tdata: found_value
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_data: bucket_count
//
// an item goes through the two fmix64 multiplies on the shared multiplier, the
// bit-serial remainder, the bucket head read, one node read per node of the
// chain walk, the hash handoff, the end-of-chain check and the commit
// after reset a clearing pass over all BUCKETS bucket heads empties them;
// no item is taken meanwhile, configuration writes are taken at any time
// a held result does not block the next item; it only delays the commit
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_map_engine #(
  parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
  parameter int NODES   = chm_pkg::DEF_NODES
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // key [63:0], value [127:64]
  input  wire logic [1:0]   in_tuser,   // mode [1:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [63:0]  out_tdata,  // found_value [63:0]
  output logic      [2:0]   out_tuser,  // status [2:0]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [10:0]  cfg_data    // bucket_count
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = $clog2(NODES + 1);
  localparam int BCNT_MAX = (BUCKETS > 2047) ? 2047 : BUCKETS;
  localparam logic [LW-1:0] NIL = LW'(NODES);

  chm_pkg::eng_state_t state_r, state_nxt;
  logic [chm_pkg::CFG_W-1:0] bcnt_r, bcnt_nxt;
  logic [BW-1:0]  clr_r, clr_nxt;
  logic [LW-1:0]  sc_r, sc_nxt;
  logic [LW-1:0]  fresh_r, fresh_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [1:0]     mode_r, mode_nxt;
  logic [63:0]    key_r, key_nxt;
  logic [63:0]    val_r, val_nxt;
  logic [BW-1:0]  bidx_r, bidx_nxt;
  logic [LW-1:0]  head_r, head_nxt;
  logic [LW-1:0]  cur_r, cur_nxt;
  logic [LW-1:0]  prev_r, prev_nxt;
  logic [LW-1:0]  nlink_r, nlink_nxt;
  logic           hit_r, hit_nxt;
  logic [63:0]    fval_r, fval_nxt;
  logic [63:0]    out_data_r, out_data_nxt;
  logic [2:0]     out_stat_r, out_stat_nxt;

  // memories
  logic [LW-1:0]  head_mem [BUCKETS];
  logic [63:0]    key_mem  [NODES];
  logic [63:0]    val_mem  [NODES];
  logic [LW-1:0]  link_mem [NODES];
  logic [NW-1:0]  fstk_mem [NODES];
  logic [LW-1:0]  head_q, link_q;
  logic [63:0]    key_q, val_q;
  logic [NW-1:0]  fstk_q;

  logic           head_we, node_we, link_we, fstk_we;
  logic [BW-1:0]  head_wa;
  logic [LW-1:0]  head_wd, link_wd;
  logic [NW-1:0]  node_wa, link_wa, fstk_wa, fstk_ra;
  logic [NW-1:0]  pop_idx;
  logic           pool_full;
  logic           commit;
  logic [chm_pkg::CFG_W-1:0] cfg_clamp;

  chm_pkg::hash_req_t hreq;
  chm_pkg::hash_rsp_t hrsp;

  chm_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  // bucket count saturates into its legal range
  always_comb begin
    cfg_clamp = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamp = chm_pkg::CFG_W'(1);
    end else if (32'(cfg_data) > BCNT_MAX) begin
      cfg_clamp = chm_pkg::CFG_W'(BCNT_MAX);
    end
  end

  assign cfg_ready = 1'b1;
  assign bcnt_nxt  = cfg_valid ? cfg_clamp : bcnt_r;

  assign in_tready  = (state_r == chm_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  assign pop_idx   = (sc_r != '0) ? fstk_q : fresh_r[NW-1:0];
  assign pool_full = (sc_r == '0) && (fresh_r == NIL);
  assign fstk_ra   = NW'(sc_r - 1'b1);
  assign commit    = !out_valid_r || out_tready;

  assign hreq.start   = (state_r == chm_pkg::S_IDLE) && in_tvalid;
  assign hreq.key     = in_tdata[63:0];
  assign hreq.divisor = bcnt_r;

  // sequencer: clearing pass, then per item hash, head read, chain walk, commit and result
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    sc_nxt        = sc_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    bidx_nxt      = bidx_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    nlink_nxt     = nlink_r;
    hit_nxt       = hit_r;
    fval_nxt      = fval_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    head_we       = 1'b0;
    head_wa       = bidx_r;
    head_wd       = NIL;
    node_we       = 1'b0;
    node_wa       = pop_idx;
    link_we       = 1'b0;
    link_wa       = pop_idx;
    link_wd       = head_r;
    fstk_we       = 1'b0;
    fstk_wa       = sc_r[NW-1:0];
    case (state_r)
      chm_pkg::S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = chm_pkg::S_IDLE;
        end
      end
      chm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          key_nxt   = in_tdata[63:0];
          val_nxt   = in_tdata[127:64];
          state_nxt = chm_pkg::S_HASH;
        end
      end
      chm_pkg::S_HASH: begin
        if (hrsp.done) begin
          bidx_nxt  = BW'(hrsp.bucket);
          state_nxt = chm_pkg::S_HEAD;
        end
      end
      chm_pkg::S_HEAD: state_nxt = chm_pkg::S_HEADW;
      chm_pkg::S_HEADW: begin
        head_nxt  = head_q;
        cur_nxt   = head_q;
        prev_nxt  = NIL;
        hit_nxt   = 1'b0;
        state_nxt = chm_pkg::S_NODE;
      end
      chm_pkg::S_NODE: begin
        state_nxt = (cur_r >= NIL) ? chm_pkg::S_ACT : chm_pkg::S_NODEW;
      end
      chm_pkg::S_NODEW: begin
        if (key_q == key_r) begin
          hit_nxt   = 1'b1;
          fval_nxt  = val_q;
          nlink_nxt = link_q;
          state_nxt = chm_pkg::S_ACT;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_q;
          state_nxt = chm_pkg::S_NODE;
        end
      end
      chm_pkg::S_ACT: begin
        if (commit) begin
          out_stat_nxt  = chm_pkg::ST_NOT_FOUND;
          out_data_nxt  = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = chm_pkg::S_IDLE;
          case (mode_r)
            chm_pkg::MODE_LOOKUP: begin
              if (hit_r) begin
                out_stat_nxt = chm_pkg::ST_OK;
                out_data_nxt = fval_r;
              end
            end
            chm_pkg::MODE_INSERT: begin
              if (val_r == '0) begin
                out_stat_nxt = chm_pkg::ST_ZERO_VAL;
              end else if (hit_r) begin
                out_stat_nxt = chm_pkg::ST_PRESENT;
              end else if (pool_full) begin
                out_stat_nxt = chm_pkg::ST_FULL;
              end else begin
                node_we = 1'b1;
                link_we = 1'b1;
                head_we = 1'b1;
                head_wd = LW'(pop_idx);
                if (sc_r != '0) begin
                  sc_nxt = sc_r - 1'b1;
                end else begin
                  fresh_nxt = fresh_r + 1'b1;
                end
                out_stat_nxt = chm_pkg::ST_OK;
              end
            end
            chm_pkg::MODE_DELETE: begin
              if (hit_r) begin
                if (prev_r < NIL) begin
                  link_we = 1'b1;
                  link_wa = prev_r[NW-1:0];
                  link_wd = nlink_r;
                end else begin
                  head_we = 1'b1;
                  head_wd = nlink_r;
                end
                if (sc_r < NIL) begin
                  fstk_we = 1'b1;
                  sc_nxt  = sc_r + 1'b1;
                end
                out_stat_nxt = chm_pkg::ST_OK;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = chm_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chm_pkg::S_CLEAR;
      bcnt_r      <= chm_pkg::CFG_W'(BCNT_MAX);
      clr_r       <= '0;
      sc_r        <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bcnt_r      <= bcnt_nxt;
      clr_r       <= clr_nxt;
      sc_r        <= sc_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    bidx_r     <= bidx_nxt;
    head_r     <= head_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    nlink_r    <= nlink_nxt;
    hit_r      <= hit_nxt;
    fval_r     <= fval_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[bidx_r];
  end

  // node key and value memories
  always_ff @(posedge clk) begin
    if (node_we) begin
      key_mem[node_wa] <= key_r;
      val_mem[node_wa] <= val_r;
    end
    key_q <= key_mem[cur_r[NW-1:0]];
    val_q <= val_mem[cur_r[NW-1:0]];
  end

  // node link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[cur_r[NW-1:0]];
  end

  // free node stack, holding returned nodes only
  always_ff @(posedge clk) begin
    if (fstk_we) begin
      fstk_mem[fstk_wa] <= cur_r[NW-1:0];
    end
    fstk_q <= fstk_mem[fstk_ra];
  end

`ifndef SYNTH
  a_free_le_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= fresh_r)
    else $error("free stack holds more nodes than were ever handed out");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NIL)
    else $error("fresh node counter ran past the pool");

  a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    hrsp.done |-> state_r == chm_pkg::S_HASH)
    else $error("hash result arrived outside the hash wait");

  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chm_pkg::S_ACT) && commit |=> (state_r == chm_pkg::S_IDLE) && out_valid_r)
    else $error("commit did not produce a result");
`endif

endmodule

`default_nettype wire

// ===== sv/chm_mul32.sv =====
// chm_mul32: shared 32 x 32 multiplier with registered product
// depends on nothing but the clock
`timescale 1ns / 1ps
`default_nettype none

module chm_mul32 (
  input  wire logic        clk,
  input  wire logic [31:0] mul_a,
  input  wire logic [31:0] mul_b,
  output logic      [63:0] mul_p
);

  logic [63:0] prod_r;

  // one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

`default_nettype wire

// ===== sv/chm_hash.sv =====
// chm_hash: fmix64 of a key on a shared 32-bit multiplier, then a bit-serial
// remainder by the bucket count; depends on chm_pkg and chm_mul32
`timescale 1ns / 1ps
`default_nettype none

module chm_hash (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire chm_pkg::hash_req_t req,
  output chm_pkg::hash_rsp_t     rsp
);

  chm_pkg::hash_state_t hs_r, hs_nxt;
  logic [1:0]                st_r, st_nxt;
  logic                      pass_r, pass_nxt;
  logic [5:0]                cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [63:0]               x_r, x_nxt;
  logic [63:0]               acc_r, acc_nxt;
  logic [chm_pkg::CFG_W-1:0] rem_r, rem_nxt;
  logic [chm_pkg::CFG_W-1:0] dv_r, dv_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] csel;
  logic [63:0] fin;
  logic [chm_pkg::CFG_W:0] trial;

  chm_mul32 u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // sequencer: two 64-bit multiplies from three partial products each,
  // then one remainder bit per cycle
  always_comb begin
    hs_nxt   = hs_r;
    st_nxt   = st_r;
    pass_nxt = pass_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    mul_a    = '0;
    mul_b    = '0;
    csel     = pass_r ? chm_pkg::FMIX_C2 : chm_pkg::FMIX_C1;
    fin      = acc_r + {mul_p[31:0], 32'h0};
    trial    = {rem_r, x_r[63]};
    case (hs_r)
      chm_pkg::H_IDLE: begin
        if (req.start) begin
          x_nxt    = req.key ^ (req.key >> chm_pkg::FMIX_SHIFT);
          dv_nxt   = req.divisor;
          st_nxt   = '0;
          pass_nxt = 1'b0;
          hs_nxt   = chm_pkg::H_MUL;
        end
      end
      chm_pkg::H_MUL: begin
        st_nxt = st_r + 2'd1;
        case (st_r)
          2'd0: begin
            mul_a = x_r[31:0];
            mul_b = csel[31:0];
          end
          2'd1: begin
            mul_a   = x_r[31:0];
            mul_b   = csel[63:32];
            acc_nxt = mul_p;
          end
          2'd2: begin
            mul_a   = x_r[63:32];
            mul_b   = csel[31:0];
            acc_nxt = fin;
          end
          default: begin
            x_nxt = fin ^ (fin >> chm_pkg::FMIX_SHIFT);
            if (pass_r) begin
              rem_nxt = '0;
              cnt_nxt = '0;
              hs_nxt  = chm_pkg::H_DIV;
            end else begin
              pass_nxt = 1'b1;
            end
          end
        endcase
      end
      chm_pkg::H_DIV: begin
        if (trial >= {1'b0, dv_r}) begin
          rem_nxt = chm_pkg::CFG_W'(trial - {1'b0, dv_r});
        end else begin
          rem_nxt = trial[chm_pkg::CFG_W-1:0];
        end
        x_nxt   = {x_r[62:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          done_nxt = 1'b1;
          hs_nxt   = chm_pkg::H_IDLE;
        end
      end
      default: hs_nxt = chm_pkg::H_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r   <= chm_pkg::H_IDLE;
      done_r <= 1'b0;
    end else begin
      hs_r   <= hs_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    pass_r <= pass_nxt;
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    dv_r   <= dv_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.bucket = rem_r;

endmodule

`default_nettype wire
